// ===== sv/tpd_pkg.sv =====
package tpd_pkg;

  localparam int DefFracBits = 16;
  localparam int ValW = 32;
  localparam int SqW = 2 * ValW + 2;
  localparam int RootW = ValW + 1;
  localparam int DenW = 2 * ValW + 1;
  localparam int AddrW = 3;
  localparam int RegSelBit = 2;

  localparam logic RegSpeed = 1'b0;
  localparam logic RegAccel = 1'b1;

  typedef struct packed {
    logic              short_len;
    logic              triang;
    logic [ValW-1:0]   vs;
    logic [ValW-1:0]   ve;
    logic [ValW-1:0]   a;
    logic [SqW-1:0]    num;
    logic [DenW-1:0]   den;
  } side_t;

endpackage

// ===== sv/tpd_front.sv =====
module tpd_front import tpd_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [ValW-1:0] travel,
  input  logic [ValW-1:0] entry_speed,
  input  logic [ValW-1:0] exit_speed,
  input  logic [ValW-1:0] speed_limit,
  input  logic [ValW-1:0] accel_limit,
  output logic            out_valid,
  output logic [SqW-2:0]  x,
  output side_t           side
);

  localparam logic [ValW-1:0] Half = ValW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [ValW-1:0] LenMin =
    ValW'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

  logic [ValW-1:0] v_lim, a_lim, vs_c, ve_c;

  // stage 1: limits and clamping
  logic            vld1;
  logic [ValW-1:0] v1, a1, vs1, ve1, len1, dvs1, dve1;
  logic            short1;

  // stage 2: products
  logic            vld2;
  logic [2*ValW-1:0] al2, vsq2, vesq2, vvsq2, dvssq2, dvesq2, av2;
  logic [ValW-1:0] vs2, ve2, a2;
  logic            short2;

  // stage 3: sums and branch choice
  logic            vld3;
  logic [SqW-1:0]  q3;
  side_t           side3;

  logic [SqW-1:0]  q_sum, num_sum;

  always_comb begin
    v_lim = (speed_limit < Half) ? Half : speed_limit;
    a_lim = (accel_limit < Half) ? Half : accel_limit;
    vs_c  = (entry_speed > v_lim) ? v_lim : entry_speed;
    ve_c  = (exit_speed > v_lim) ? v_lim : exit_speed;
  end

  assign q_sum = SqW'(vsq2) + SqW'(vesq2) + (SqW'(al2) << 1);
  assign num_sum = SqW'(dvssq2) + SqW'(dvesq2) + (SqW'(al2) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1     <= v_lim;
      a1     <= a_lim;
      vs1    <= vs_c;
      ve1    <= ve_c;
      len1   <= travel;
      dvs1   <= v_lim - vs_c;
      dve1   <= v_lim - ve_c;
      short1 <= travel < LenMin;

      al2    <= a1 * len1;
      vsq2   <= vs1 * vs1;
      vesq2  <= ve1 * ve1;
      vvsq2  <= v1 * v1;
      dvssq2 <= dvs1 * dvs1;
      dvesq2 <= dve1 * dve1;
      av2    <= a1 * v1;
      vs2    <= vs1;
      ve2    <= ve1;
      a2     <= a1;
      short2 <= short1;

      q3              <= q_sum;
      side3.short_len <= short2;
      side3.triang    <= q_sum <= (SqW'(vvsq2) << 1);
      side3.vs        <= vs2;
      side3.ve        <= ve2;
      side3.a         <= a2;
      side3.num       <= num_sum;
      side3.den       <= DenW'(av2) << 1;
    end
  end

  assign out_valid = vld3;
  assign x = q3[SqW-1:1];
  assign side = side3;

endmodule

// ===== sv/tpd_sqrt.sv =====
module tpd_sqrt import tpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SqW-2:0]   x,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [RootW-1:0] root,
  output side_t            side_out
);

  localparam int RemW = SqW - 1;
  localparam int TrW = SqW + 1;

  logic             vld_q  [RootW+1];
  logic [RemW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];
  side_t            side_q [RootW+1];

  assign vld_q[0]  = in_valid;
  assign rem_q[0]  = x;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int B = RootW - 1 - k;
    logic [TrW-1:0] trial;
    logic [TrW-1:0] rem_ext;
    logic           take;

    assign trial   = (TrW'(root_q[k]) << (B + 1)) | (TrW'(1) << (2 * B));
    assign rem_ext = TrW'(rem_q[k]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= take ? RemW'(rem_ext - trial) : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (RootW'(1) << B)) : root_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = vld_q[RootW];
  assign root      = root_q[RootW];
  assign side_out  = side_q[RootW];

endmodule

// ===== sv/tpd_div.sv =====
module tpd_div import tpd_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RootW-1:0] root,
  input  side_t            side,
  output logic             out_valid,
  output logic [ValW-1:0]  duration,
  output logic             triangular,
  output logic             saturated
);

  localparam int NW = SqW + FRAC_BITS;
  localparam int HiW = NW - ValW;
  localparam int CW = (HiW > DenW) ? HiW : DenW;
  localparam int TW = DenW + 1;

  logic [RootW-1:0] dvs, dve;
  logic [RootW:0]   dsum;

  // numerator and divisor select
  logic             vld_a;
  logic [NW-1:0]    n_a;
  logic [DenW-1:0]  d_a;
  logic             tri_a, short_a;

  // overflow check
  logic             vld_b;
  logic [ValW-1:0]  lo_b;
  logic [DenW-1:0]  d_b;
  logic [DenW-1:0]  rem_b;
  logic             ovf_b, tri_b, short_b;

  logic             vld_q   [ValW+1];
  logic [DenW-1:0]  rem_q   [ValW+1];
  logic [ValW-1:0]  quo_q   [ValW+1];
  logic [ValW-1:0]  lo_q    [ValW+1];
  logic [DenW-1:0]  d_q     [ValW+1];
  logic             ovf_q   [ValW+1];
  logic             tri_q   [ValW+1];
  logic             short_q [ValW+1];

  logic             vld_o;
  logic [ValW-1:0]  dur_o;
  logic             tri_o, sat_o;

  assign dvs  = (root > RootW'(side.vs)) ? root - RootW'(side.vs) : '0;
  assign dve  = (root > RootW'(side.ve)) ? root - RootW'(side.ve) : '0;
  assign dsum = (RootW + 1)'(dvs) + (RootW + 1)'(dve);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld_a <= in_valid;
      vld_b <= vld_a;
      vld_o <= vld_q[ValW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_a     <= side.triang ? (NW'(dsum) << FRAC_BITS) : (NW'(side.num) << FRAC_BITS);
      d_a     <= side.triang ? DenW'(side.a) : side.den;
      tri_a   <= side.triang;
      short_a <= side.short_len;

      lo_b    <= n_a[ValW-1:0];
      d_b     <= d_a;
      rem_b   <= DenW'(n_a[NW-1:ValW]);
      ovf_b   <= CW'(n_a[NW-1:ValW]) >= CW'(d_a);
      tri_b   <= tri_a;
      short_b <= short_a;

      dur_o <= short_q[ValW] ? '0 : (ovf_q[ValW] ? '1 : quo_q[ValW]);
      tri_o <= !short_q[ValW] && tri_q[ValW];
      sat_o <= !short_q[ValW] && ovf_q[ValW];
    end
  end

  assign vld_q[0]   = vld_b;
  assign rem_q[0]   = rem_b;
  assign quo_q[0]   = '0;
  assign lo_q[0]    = lo_b;
  assign d_q[0]     = d_b;
  assign ovf_q[0]   = ovf_b;
  assign tri_q[0]   = tri_b;
  assign short_q[0] = short_b;

  for (genvar k = 0; k < ValW; k++) begin : g_step
    localparam int B = ValW - 1 - k;
    logic [TW-1:0] t;
    logic          ge;

    assign t  = {rem_q[k], lo_q[k][B]};
    assign ge = t >= TW'(d_q[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]   <= ge ? DenW'(t - TW'(d_q[k])) : DenW'(t);
        quo_q[k+1]   <= ge ? (quo_q[k] | (ValW'(1) << B)) : quo_q[k];
        lo_q[k+1]    <= lo_q[k];
        d_q[k+1]     <= d_q[k];
        ovf_q[k+1]   <= ovf_q[k];
        tri_q[k+1]   <= tri_q[k];
        short_q[k+1] <= short_q[k];
      end
    end
  end

  assign out_valid  = vld_o;
  assign duration   = dur_o;
  assign triangular = tri_o;
  assign saturated  = sat_o;

endmodule

// ===== sv/trapezoidal_profile_duration.sv =====
// Trapezoidal velocity profile duration.
// Input stream s_*: one request per item with path length, start speed and
// end speed, unsigned fixed point with FRAC_BITS fraction bits.
// Output stream m_*: duration in seconds (same format), plus flags telling
// whether the triangular profile was used and whether the duration clipped.
// Speed and acceleration limits are set through the APB port, register 0
// at address 0 and register 1 at address 4; both reset to 2.0.
// Pipeline stages: 3 front stages (clamp, multiply, sum), 33 stages of
// the square root (one root bit each), 2 stages to form the division
// operands and check overflow, 32 stages of the divider (one quotient bit
// each) and the output register. One request per cycle unless stalled.
// Reset empties the pipeline and restores the limit registers.
// When the receiver stalls the whole pipeline holds and s_tready drops
// while the output register holds a request that m_tready does not take;
// nothing is lost or repeated.
module trapezoidal_profile_duration import tpd_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [3*ValW-1:0]  s_tdata,   // travel, entry_speed, exit_speed
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [ValW-1:0]    m_tdata,   // duration
  output logic [1:0]         m_tuser,   // triangular, saturated
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [ValW-1:0]    pwdata,
  output logic [ValW-1:0]    prdata,
  output logic               pready
);

  localparam logic [ValW-1:0] LimitReset = ValW'(64'd2 << FRAC_BITS);

  logic [ValW-1:0]  speed_limit, accel_limit;
  logic             en;
  logic             front_valid, sqrt_valid;
  logic [SqW-2:0]   front_x;
  side_t            front_side, sqrt_side;
  logic [RootW-1:0] sqrt_root;
  logic             wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LimitReset;
      accel_limit <= LimitReset;
    end else if (wr) begin
      unique case (paddr[RegSelBit])
        RegSpeed: speed_limit <= pwdata;
        RegAccel: accel_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[RegSelBit])
      RegSpeed: prdata = speed_limit;
      RegAccel: prdata = accel_limit;
      default:  prdata = '0;
    endcase
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  tpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid && s_tready),
    .travel      (s_tdata[ValW-1:0]),
    .entry_speed (s_tdata[2*ValW-1:ValW]),
    .exit_speed  (s_tdata[3*ValW-1:2*ValW]),
    .speed_limit (speed_limit),
    .accel_limit (accel_limit),
    .out_valid   (front_valid),
    .x           (front_x),
    .side        (front_side)
  );

  tpd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .x         (front_x),
    .side_in   (front_side),
    .out_valid (sqrt_valid),
    .root      (sqrt_root),
    .side_out  (sqrt_side)
  );

  tpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sqrt_valid),
    .root       (sqrt_root),
    .side       (sqrt_side),
    .out_valid  (m_tvalid),
    .duration   (m_tdata),
    .triangular (m_tuser[0]),
    .saturated  (m_tuser[1])
  );

endmodule

// ===== sv/tpd_checker.sv =====
module tpd_checker import tpd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [ValW-1:0]   m_tdata,
  input logic [1:0]        m_tuser,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [ValW-1:0]   pwdata,
  input logic [ValW-1:0]   prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output request changed while stalled");

  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '1)
    else $error("saturated duration not all ones");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && $past(psel && penable && pwrite) && paddr == $past(paddr)
    |-> prdata == $past(pwdata))
    else $error("register read does not return last write");

endmodule

bind trapezoidal_profile_duration tpd_checker u_tpd_checker (.*);

// ===== tb/trapezoidal_profile_duration_test.sv =====
module trapezoidal_profile_duration_test;
  import tpd_pkg::*;

  localparam int FracBits = DefFracBits;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [ValW-1:0] duration;
    logic            triang;
    logic            sat;
  } profile_t;

  typedef struct {
    logic [ValW-1:0] len;
    logic [ValW-1:0] vs;
    logic [ValW-1:0] ve;
    bit              known;
    profile_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [3*ValW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ValW-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [ValW-1:0] pwdata = '0;
  logic [ValW-1:0] prdata;
  logic pready;

  logic [ValW-1:0] speed_cfg;
  logic [ValW-1:0] accel_cfg;
  profile_t pending_profiles[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_on = 1'b0;

  trapezoidal_profile_duration i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what);
    errors++;
    $display("error: %s", what);
  endtask

  function automatic logic [63:0] root_floor(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic profile_t profile_time(input logic [ValW-1:0] len_in,
                                            input logic [ValW-1:0] vs_in,
                                            input logic [ValW-1:0] ve_in);
    logic [127:0] v, a, vs, ve, len, two_al, q, num, quot;
    logic [63:0] p, d;
    profile_t r;
    r = '0;
    len = 128'(len_in);
    v = (speed_cfg < (1 << (FracBits - 1))) ? 128'(1 << (FracBits - 1)) : 128'(speed_cfg);
    a = (accel_cfg < (1 << (FracBits - 1))) ? 128'(1 << (FracBits - 1)) : 128'(accel_cfg);
    if (len * 1000000 < (128'd1 << FracBits)) return r;
    vs = (128'(vs_in) > v) ? v : 128'(vs_in);
    ve = (128'(ve_in) > v) ? v : 128'(ve_in);
    two_al = 2 * a * len;
    q = vs * vs + ve * ve + two_al;
    r.triang = (q <= 2 * v * v);
    if (!r.triang) begin
      num = (v - vs) * (v - vs) + (v - ve) * (v - ve) + two_al;
      quot = (num << FracBits) / (2 * a * v);
    end else begin
      p = root_floor(q >> 1);
      d = ((p > vs) ? p - vs[63:0] : 64'd0) + ((p > ve) ? p - ve[63:0] : 64'd0);
      quot = 128'((d << FracBits) / a[63:0]);
    end
    if (quot > 128'hFFFF_FFFF) begin
      r.duration = '1;
      r.sat = 1'b1;
    end else begin
      r.duration = quot[ValW-1:0];
    end
    return r;
  endfunction

  task automatic write_limit(input logic reg_sel, input logic [ValW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({reg_sel, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegSpeed) speed_cfg = value;
    else accel_cfg = value;
  endtask

  task automatic wait_drained();
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input logic [ValW-1:0] len, input logic [ValW-1:0] vs,
                              input logic [ValW-1:0] ve, input bit known,
                              input profile_t res, input bit gaps);
    profile_t exp_p;
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ve, vs, len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_p = profile_time(len, vs, ve);
    if (known && exp_p != res) report($sformatf("predictor disagrees with table row %h", len));
    pending_profiles.push_back(known ? res : exp_p);
  endtask

  function automatic logic [ValW-1:0] rand_speed();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32'h0008_0000);
      1: return $urandom;
      2: return '1;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [ValW-1:0] rand_len();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom;
      2: return '1;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    profile_t got;
    profile_t want;
    if (!rst) begin
      if (rx_on) begin
        if ($urandom_range(0, 99) < 8) m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 50) m_tready <= 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got.duration = m_tdata;
        got.triang = m_tuser[0];
        got.sat = m_tuser[1];
        if (pending_profiles.size() == 0) begin
          report("result with no request pending");
        end else begin
          want = pending_profiles.pop_front();
          if (got.duration != want.duration)
            report($sformatf("duration %h want %h", got.duration, want.duration));
          if (got.triang != want.triang)
            report($sformatf("triangular %b want %b", got.triang, want.triang));
          if (got.sat != want.sat) report($sformatf("saturated %b want %b", got.sat, want.sat));
        end
      end
    end
  end

  row_t requests[] = '{
    '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{32'h0, '1, '1, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{32'h1, 32'h0, 32'h0, 1'b0, '0},
    '{32'h0004_0000, 32'h0, 32'h0, 1'b1, '{32'h0003_0000, 1'b0, 1'b0}},
    '{32'h0001_0000, 32'h0, 32'h0, 1'b0, '0},
    '{32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 1'b1, '{32'h0002_0000, 1'b0, 1'b0}},
    '{32'h0004_0000, '1, '1, 1'b0, '0},
    '{'1, 32'h0, 32'h0, 1'b0, '0},
    '{'1, '1, 32'h0, 1'b0, '0},
    '{32'h0000_8000, 32'h0001_0000, 32'h0, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
  };

  logic [ValW-1:0] cfg_points[8] = '{32'h0, 32'h1, 32'h0000_8000, 32'h0002_0000,
                                     32'h0010_0000, '1, 32'h0000_7FFF, 32'h0001_8000};

  initial begin
    logic [ValW-1:0] vlen;
    speed_cfg = 32'h0002_0000;
    accel_cfg = 32'h0002_0000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    m_tready <= 1'b1;
    @(posedge clk);
    rx_on = 1'b1;
    foreach (requests[i])
      send_request(requests[i].len, requests[i].vs, requests[i].ve,
                   requests[i].known, requests[i].res, 1'b0);
    s_tvalid <= 1'b0;
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      write_limit(RegSpeed, (phase < 8) ? cfg_points[phase] : rand_speed());
      write_limit(RegAccel, (phase < 8) ? cfg_points[7 - phase] : rand_speed());
      for (int n = 0; n < 88; n++) begin
        vlen = rand_len();
        send_request(vlen, rand_speed(), rand_speed(), 1'b0, '0, 1'b1);
      end
      s_tvalid <= 1'b0;
    end
    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== trapezoidal_profile_duration.f =====
sv/tpd_pkg.sv
sv/tpd_front.sv
sv/tpd_sqrt.sv
sv/tpd_div.sv
sv/trapezoidal_profile_duration.sv
sv/tpd_checker.sv
tb/trapezoidal_profile_duration_test.sv
